/* design/assert_macros.svh */
// Assertion helpers used by pixel_color_matrix_hls.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define PCM_ASSERT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pixel color matrix check failed");
// Next-cycle implication, checked while out of reset.
`define PCM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pixel color matrix check failed");
`else
`define PCM_ASSERT(lbl, pre, post)
`define PCM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/pcm_pkg.sv */
package pcm_pkg;

	// One pixel on the input and on the output channel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pcm_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
	} pcm_out_t;

	// Fixed-point constants.
	localparam int ONE_Q16    = 65536;
	localparam int HUE_PERIOD = 6 * ONE_Q16;

	// Pipelined divider: quotient width, bits per stage and latency.
	localparam int DIV_QW  = 17;
	localparam int DIV_BPS = 2;
	localparam int DIV_LAT = (DIV_QW + DIV_BPS - 1) / DIV_BPS;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;
	localparam logic [CFG_IDX_W-1:0] REG_HLS_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_THIRD  = 2'd3;
	localparam logic [CFG_W-1:0] COEF_FIRST_RST  = 64'd4096;
	localparam logic [CFG_W-1:0] COEF_SECOND_RST = 64'd4096 << 16;
	localparam logic [CFG_W-1:0] COEF_THIRD_RST  = 64'd4096 << 32;

	// Hue segment of one output channel.
	localparam logic [1:0] SEG_RISE = 2'd0;
	localparam logic [1:0] SEG_HIGH = 2'd1;
	localparam logic [1:0] SEG_FALL = 2'd2;
	localparam logic [1:0] SEG_LOW  = 2'd3;

endpackage

/* design/pcm_delay.sv */
module pcm_delay import pcm_pkg::*; #(
	parameter int W = 8,
	parameter int N = 9
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_s [N];

	// Shift line that advances with the pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				sr_s[i] <= sr_s[i-1];
			end
		end
	end

	assign q = sr_s[N-1];

endmodule

/* design/pcm_div.sv */
module pcm_div import pcm_pkg::*; #(
	parameter int NW = 36,
	parameter int DW = 19
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NW-1:0]     num,
	input  logic [DW-1:0]     den,
	output logic [DIV_QW-1:0] quo
);

	localparam int NS = DIV_LAT;
	localparam int QP = NS * DIV_BPS;

	logic [DW-1:0] rem_s [NS];
	logic [DW-1:0] den_s [NS];
	logic [QP-1:0] low_s [NS];
	logic [QP-1:0] quo_s [NS];

	// Restoring division, DIV_BPS quotient bits per stage. The quotient is
	// known to fit in QP bits, so the top of the numerator starts as remainder.
	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [DW-1:0] r_in, d_in, r_nx;
		logic [QP-1:0] l_in, q_in, l_nx, q_nx;

		if (k == 0) begin : g_first
			assign r_in = DW'(num >> QP);
			assign l_in = num[QP-1:0];
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign l_in = low_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
		end

		always_comb begin
			logic [DW:0] t;
			r_nx = r_in;
			l_nx = l_in;
			q_nx = q_in;
			t = '0;
			for (int b = 0; b < DIV_BPS; b++) begin
				t = {r_nx, l_nx[QP-1]};
				l_nx = {l_nx[QP-2:0], 1'b0};
				if (t >= {1'b0, d_in}) begin
					r_nx = DW'(t - {1'b0, d_in});
					q_nx = {q_nx[QP-2:0], 1'b1};
				end else begin
					r_nx = t[DW-1:0];
					q_nx = {q_nx[QP-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				den_s[k] <= d_in;
				low_s[k] <= l_nx;
				quo_s[k] <= q_nx;
			end
		end
	end

	assign quo = quo_s[NS-1][DIV_QW-1:0];

endmodule

/* design/pixel_color_matrix_hls.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_pix (pcm_in_t)
// out       output     out_valid / out_ready  out_pix (pcm_out_t)
// cfg       input      cfg_we                 cfg_index, cfg_wdata
//
// One pixel per clock is taken and given, unless a stall on the output holds the flow.
// Reset clears the valid chain and loads hls_mode 0 and the identity matrix.
// A stall on the output freezes every stage at once; nothing is lost or repeated.

`include "assert_macros.svh"

module pixel_color_matrix_hls import pcm_pkg::*; #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pcm_in_t              in_pix,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pcm_out_t             out_pix,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int PW = PIXEL_BITS;
	localparam logic [PW-1:0] PIX_MAX = '1;
	localparam int Q16_LAT = 2;
	localparam int KS = 16 + 2 * PW;
	localparam int KW = PW + 18;
	localparam int QRW = 2 * PW + 34;
	localparam logic [63:0] PIX_MAX64 = 64'(PIX_MAX);
	localparam logic [63:0] RECIP64 = ((64'd1 << KS) + PIX_MAX64 - 64'd1) / PIX_MAX64;
	localparam logic [KW-1:0] RECIP = RECIP64[KW-1:0];
	localparam logic [QRW-1:0] RND_BIAS = QRW'(RECIP64 * (PIX_MAX64 >> 1));
	localparam int VL = Q16_LAT + DIV_LAT + 11;
	localparam int V_D2 = Q16_LAT + DIV_LAT;
	localparam int V_C5 = Q16_LAT + DIV_LAT + 4;
	localparam int SIDE_W = 3 * 17 + 17 + 1 + PW;
	localparam logic [16:0] ONE17 = 17'(ONE_Q16);
	localparam logic [16:0] HALF17 = 17'(ONE_Q16 / 2);
	localparam logic [18:0] T_ONE = 19'(ONE_Q16);
	localparam logic [18:0] T_TWO = 19'(2 * ONE_Q16);
	localparam logic [18:0] T_THREE = 19'(3 * ONE_Q16);
	localparam logic [18:0] T_FOUR = 19'(4 * ONE_Q16);
	localparam logic [18:0] T_PERIOD = 19'(HUE_PERIOD);

	function automatic logic [16:0] clamp_unit(input logic signed [23:0] x);
		if (x < 0) begin
			return '0;
		end else if (x > 24'sd65536) begin
			return ONE17;
		end
		return x[16:0];
	endfunction

	// Residue modulo three, by summing base-four digits.
	function automatic logic [1:0] mod3(input logic [10:0] u);
		logic [4:0] s1;
		logic [2:0] s2;
		logic [2:0] s3;
		s1 = 5'(u[1:0]) + 5'(u[3:2]) + 5'(u[5:4]) + 5'(u[7:6]) + 5'(u[9:8]) + 5'(u[10]);
		s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
		s3 = 3'(s2[1:0]) + 3'(s2[2]);
		return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
	endfunction

	// Configuration registers.
	logic             hls_mode_q;
	logic [CFG_W-1:0] coef_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hls_mode_q <= 1'b0;
			coef_q[0]  <= COEF_FIRST_RST;
			coef_q[1]  <= COEF_SECOND_RST;
			coef_q[2]  <= COEF_THIRD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HLS_MODE:    hls_mode_q <= cfg_wdata[0];
				REG_COEF_FIRST:  coef_q[0] <= cfg_wdata;
				REG_COEF_SECOND: coef_q[1] <= cfg_wdata;
				REG_COEF_THIRD:  coef_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Global advance: every stage moves when the output register is free.
	logic          en;
	logic [VL-1:0] vld_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[VL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[VL-2:0], in_valid};
		end
	end

	// Channel scaling to Q.16, rounded to nearest. The division by PIX_MAX is a
	// reciprocal multiplication over two registers; the rounding half is folded
	// into a constant bias so the quotient is exact for every sample.
	logic [PW-1:0]    pin [3];
	logic [PW+KW-1:0] vp_s0 [3];
	logic [16:0]      v_s0 [3];
	logic [16:0]      v [3];
	logic [PW-1:0]    alpha_d1;

	assign pin[0] = PW'(in_pix.red);
	assign pin[1] = PW'(in_pix.green);
	assign pin[2] = PW'(in_pix.blue);

	for (genvar c = 0; c < 3; c++) begin : g_q16
		logic [QRW-1:0] vsum;
		assign vsum = (QRW'(vp_s0[c]) << 16) + RND_BIAS;
		always_ff @(posedge clk) begin
			if (en) begin
				vp_s0[c] <= (PW+KW)'(pin[c]) * (PW+KW)'(RECIP);
				v_s0[c]  <= 17'(vsum >> KS);
			end
		end
	end

	assign v = v_s0;

	pcm_delay #(.W(PW), .N(Q16_LAT)) u_alpha_dly (
		.clk (clk),
		.en  (en),
		.d   (PW'(in_pix.alpha)),
		.q   (alpha_d1)
	);

	// Stage 1: min, max, lightness and the two ratio operands.
	logic [16:0] mx, mn, md, sat_den;
	logic [17:0] ms;
	logic [19:0] hue_numh;
	logic [16:0] v_s1 [3];
	logic [16:0] l_s1;
	logic        gray_s1;
	logic [33:0] sat_num_s1;
	logic [16:0] sat_den_s1;
	logic [35:0] hue_num_s1;
	logic [18:0] hue_den_s1;
	logic [PW-1:0] alpha_s1;

	always_comb begin
		mx = v[0];
		mn = v[0];
		if (v[1] < mn) mn = v[1];
		if (v[2] < mn) mn = v[2];
		if (v[1] > mx) mx = v[1];
		if (v[2] > mx) mx = v[2];
		md = mx - mn;
		ms = 18'(mx) + 18'(mn);
		sat_den = (ms < 18'(ONE_Q16)) ? ms[16:0] : 17'(18'(2 * ONE_Q16) - ms);
		if (v[0] == mx) begin
			hue_numh = 20'(6) * 20'(md) + 20'(v[1]) - 20'(v[2]);
		end else if (v[1] == mx) begin
			hue_numh = 20'(2) * 20'(md) + 20'(v[2]) - 20'(v[0]);
		end else begin
			hue_numh = 20'(4) * 20'(md) + 20'(v[0]) - 20'(v[1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1       <= v;
			l_s1       <= 17'((ms + 18'd1) >> 1);
			gray_s1    <= (md == '0);
			sat_num_s1 <= {1'b0, md, 16'b0} + 34'(sat_den >> 1);
			sat_den_s1 <= sat_den;
			hue_num_s1 <= {hue_numh, 16'b0} + 36'(3) * 36'(md);
			hue_den_s1 <= 19'(6) * 19'(md);
			alpha_s1   <= alpha_d1;
		end
	end

	// Saturation and hue ratios.
	logic [16:0] sat_q, hue_q;
	logic [SIDE_W-1:0] side_d2;
	logic [16:0] v_d2 [3];
	logic [16:0] l_d2;
	logic        gray_d2;
	logic [PW-1:0] alpha_d2;

	pcm_div #(.NW(34), .DW(17)) u_sat_div (
		.clk (clk),
		.en  (en),
		.num (sat_num_s1),
		.den (sat_den_s1),
		.quo (sat_q)
	);

	pcm_div #(.NW(36), .DW(19)) u_hue_div (
		.clk (clk),
		.en  (en),
		.num (hue_num_s1),
		.den (hue_den_s1),
		.quo (hue_q)
	);

	pcm_delay #(.W(SIDE_W), .N(DIV_LAT)) u_side_dly (
		.clk (clk),
		.en  (en),
		.d   ({v_s1[0], v_s1[1], v_s1[2], l_s1, gray_s1, alpha_s1}),
		.q   (side_d2)
	);

	assign {v_d2[0], v_d2[1], v_d2[2], l_d2, gray_d2, alpha_d2} = side_d2;

	// Stage 2: pick the matrix input vector.
	logic [16:0] hue_w;
	logic [16:0] x_s2 [3];
	logic [PW-1:0] alpha_s2;

	always_comb begin
		if (gray_d2) begin
			hue_w = '0;
		end else if (hue_q > ONE17) begin
			hue_w = hue_q - ONE17;
		end else begin
			hue_w = hue_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (hls_mode_q) begin
				x_s2[0] <= hue_w;
				x_s2[1] <= l_d2;
				x_s2[2] <= gray_d2 ? 17'd0 : sat_q;
			end else begin
				x_s2 <= v_d2;
			end
			alpha_s2 <= alpha_d2;
		end
	end

	// Stage 3: nine weight products.
	logic signed [33:0] prod_s3 [3][3];
	logic [PW-1:0] alpha_s3;

	for (genvar k = 0; k < 3; k++) begin : g_mul_col
		for (genvar j = 0; j < 3; j++) begin : g_mul_row
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s3[k][j] <= $signed({1'b0, x_s2[j]}) * $signed(coef_q[k][16*j +: 16]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s3 <= alpha_s2;
		end
	end

	// Stage 4: sum with offset, round, floor shift to Q.16.
	logic signed [23:0] m_s4 [3];
	logic [PW-1:0] alpha_s4;

	for (genvar k = 0; k < 3; k++) begin : g_acc
		logic signed [35:0] acc;
		assign acc = 36'(prod_s3[k][0]) + 36'(prod_s3[k][1]) + 36'(prod_s3[k][2])
			+ (36'($signed(coef_q[k][63:48])) <<< 16) + 36'sd2048;
		always_ff @(posedge clk) begin
			if (en) begin
				m_s4[k] <= acc[35:12];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s4 <= alpha_s3;
		end
	end

	// Stage 5: clamp lightness and saturation, wrap six times the hue.
	logic signed [26:0] x6;
	logic signed [9:0]  hq;
	logic signed [11:0] hu;
	logic [16:0] l_s5, s_s5;
	logic [18:0] t_s5;
	logic signed [23:0] m_s5 [3];
	logic [PW-1:0] alpha_s5;

	assign x6 = (27'(m_s4[0]) <<< 2) + (27'(m_s4[0]) <<< 1);
	assign hq = x6[26:17];
	assign hu = 12'(hq) + 12'sd1536;

	always_ff @(posedge clk) begin
		if (en) begin
			l_s5     <= clamp_unit(m_s4[1]);
			s_s5     <= clamp_unit(m_s4[2]);
			t_s5     <= {mod3(hu[10:0]), x6[16:0]};
			m_s5     <= m_s4;
			alpha_s5 <= alpha_s4;
		end
	end

	// Stage 6: lightness times saturation.
	logic [33:0] lsp_s6;
	logic [16:0] l_s6, s_s6;
	logic [18:0] t_s6;
	logic signed [23:0] m_s6 [3];
	logic [PW-1:0] alpha_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			lsp_s6   <= 34'(l_s5) * 34'(s_s5);
			l_s6     <= l_s5;
			s_s6     <= s_s5;
			t_s6     <= t_s5;
			m_s6     <= m_s5;
			alpha_s6 <= alpha_s5;
		end
	end

	// Stage 7: the two levels, their difference and each channel's segment.
	logic [16:0] ls;
	logic signed [19:0] m2w, m1w;
	logic [18:0] tt [3];
	logic [19:0] tr_sum;
	logic [1:0]  seg [3];
	logic [16:0] xs [3];
	logic signed [19:0] m1_s7, m2_s7, d_s7;
	logic [1:0]  seg_s7 [3];
	logic [16:0] x_s7 [3];
	logic signed [23:0] m_s7 [3];
	logic [PW-1:0] alpha_s7;

	always_comb begin
		ls = 17'((lsp_s6 + 34'd32768) >> 16);
		if (l_s6 <= HALF17) begin
			m2w = $signed({3'b0, l_s6}) + $signed({3'b0, ls});
		end else begin
			m2w = $signed({3'b0, l_s6}) + $signed({3'b0, s_s6}) - $signed({3'b0, ls});
		end
		m1w = ($signed({3'b0, l_s6}) <<< 1) - m2w;
		tr_sum = 20'(t_s6) + 20'(T_TWO);
		tt[0] = (tr_sum >= 20'(T_PERIOD)) ? 19'(tr_sum - 20'(T_PERIOD)) : tr_sum[18:0];
		tt[1] = t_s6;
		tt[2] = (t_s6 >= T_TWO) ? t_s6 - T_TWO : t_s6 + (T_PERIOD - T_TWO);
		for (int c = 0; c < 3; c++) begin
			if (tt[c] < T_ONE) begin
				seg[c] = SEG_RISE;
				xs[c]  = tt[c][16:0];
			end else if (tt[c] < T_THREE) begin
				seg[c] = SEG_HIGH;
				xs[c]  = '0;
			end else if (tt[c] < T_FOUR) begin
				seg[c] = SEG_FALL;
				xs[c]  = 17'(T_FOUR - tt[c]);
			end else begin
				seg[c] = SEG_LOW;
				xs[c]  = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s7    <= m1w;
			m2_s7    <= m2w;
			d_s7     <= m2w - m1w;
			seg_s7   <= seg;
			x_s7     <= xs;
			m_s7     <= m_s6;
			alpha_s7 <= alpha_s6;
		end
	end

	// Stage 8: slope times position inside the segment.
	logic signed [37:0] dx_s8 [3];
	logic signed [19:0] m1_s8, m2_s8;
	logic [1:0]  seg_s8 [3];
	logic signed [23:0] m_s8 [3];
	logic [PW-1:0] alpha_s8;

	for (genvar c = 0; c < 3; c++) begin : g_slope
		always_ff @(posedge clk) begin
			if (en) begin
				dx_s8[c] <= d_s7 * $signed({1'b0, x_s7[c]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s8    <= m1_s7;
			m2_s8    <= m2_s7;
			seg_s8   <= seg_s7;
			m_s8     <= m_s7;
			alpha_s8 <= alpha_s7;
		end
	end

	// Stage 9: segment value, then the mode picks the channel result.
	logic signed [23:0] r_s9 [3];
	logic [PW-1:0] alpha_s9;

	for (genvar c = 0; c < 3; c++) begin : g_seg
		logic signed [37:0] rnd;
		logic signed [23:0] segv;
		assign rnd = dx_s8[c] + 38'sd32768;
		always_comb begin
			case (seg_s8[c])
				SEG_RISE: segv = 24'(m1_s8) + 24'($signed(rnd[37:16]));
				SEG_HIGH: segv = 24'(m2_s8);
				SEG_FALL: segv = 24'(m1_s8) + 24'($signed(rnd[37:16]));
				SEG_LOW:  segv = 24'(m1_s8);
				default:  segv = 24'(m1_s8);
			endcase
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s9[c] <= hls_mode_q ? segv : m_s8[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s9 <= alpha_s8;
		end
	end

	// Stage 10: clamp to the unit range and scale to full pixel range.
	logic [PW+16:0] cp_s10 [3];
	logic [PW-1:0] alpha_s10;

	for (genvar c = 0; c < 3; c++) begin : g_scale
		always_ff @(posedge clk) begin
			if (en) begin
				cp_s10[c] <= (PW+17)'(clamp_unit(r_s9[c])) * (PW+17)'(PIX_MAX);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s10 <= alpha_s9;
		end
	end

	// Stage 11: round to nearest into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			out_pix.red_out   <= 8'((cp_s10[0] + (PW+17)'(32768)) >> 16);
			out_pix.green_out <= 8'((cp_s10[1] + (PW+17)'(32768)) >> 16);
			out_pix.blue_out  <= 8'((cp_s10[2] + (PW+17)'(32768)) >> 16);
			out_pix.alpha_out <= 8'(alpha_s10);
		end
	end

	// A stall freezes the valid chain; the saturation ratio and wrapped hue stay in range.
	`PCM_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_q))
	`PCM_ASSERT(a_sat_in_unit, vld_q[V_D2] && !gray_d2, sat_q <= ONE17)
	`PCM_ASSERT(a_hue_wrapped, vld_q[V_C5], t_s5 < T_PERIOD)

endmodule

/* dv/pcm_checker.sv */
`timescale 1ns / 1ps

// Watches both pixel channels and the register port, predicts every output
// pixel from its own copy of the settings, and compares in order.
module pcm_checker import pcm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  pcm_in_t              in_pix,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  pcm_out_t             out_pix,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   errors,
	output int                   pending
);

	localparam longint PMAX = 255;
	localparam longint ONE  = 65536;
	localparam longint TURN = 6 * 65536;

	logic             hls_on;
	logic [CFG_W-1:0] coef [3];
	pcm_out_t         expected_pixels [$];

	function automatic longint coef_of(logic [CFG_W-1:0] r, int i);
		logic [15:0] f;
		f = r[16*i +: 16];
		return longint'($signed(f));
	endfunction

	function automatic longint unit_clamp(longint x);
		if (x < 0)
			return 0;
		if (x > ONE)
			return ONE;
		return x;
	endfunction

	function automatic longint pix_to_q16(logic [7:0] x);
		longint p;
		p = longint'(x);
		return (2 * p * ONE + PMAX) / (2 * PMAX);
	endfunction

	function automatic logic [7:0] q16_to_pix(longint c);
		longint k;
		k = unit_clamp(c);
		return 8'((k * PMAX + 32768) >>> 16);
	endfunction

	// Affine column: Q.16 inputs times Q4.12 weights, plus offset, back to Q.16.
	function automatic longint matrix_col(logic [CFG_W-1:0] r, longint a, longint b,
		longint c);
		longint acc;
		acc = a * coef_of(r, 0) + b * coef_of(r, 1) + c * coef_of(r, 2)
			+ coef_of(r, 3) * 65536;
		return (acc + 2048) >>> 12;
	endfunction

	function automatic longint rounded_ratio(longint num, longint den);
		return (num * ONE + den / 2) / den;
	endfunction

	function automatic longint hue_wrap(longint t);
		longint r;
		r = t % TURN;
		return (r < 0) ? r + TURN : r;
	endfunction

	// Level of one channel at six-times-hue position t.
	function automatic longint channel_level(longint m1, longint m2, longint t);
		longint d;
		d = m2 - m1;
		if (t < ONE)
			return m1 + ((d * t + 32768) >>> 16);
		if (t < 3 * ONE)
			return m2;
		if (t < 4 * ONE)
			return m1 + ((d * (4 * ONE - t) + 32768) >>> 16);
		return m1;
	endfunction

	function automatic pcm_out_t predict_pixel(pcm_in_t p);
		longint v [3];
		longint h [3];
		longint m [3];
		longint r [3];
		longint mn, mx, md, ms, num, l, s, ls, m1, m2, t;
		pcm_out_t o;
		v[0] = pix_to_q16(p.red);
		v[1] = pix_to_q16(p.green);
		v[2] = pix_to_q16(p.blue);
		if (hls_on) begin
			// Convert to hue, lightness, saturation.
			mn = v[0];
			mx = v[0];
			for (int i = 1; i < 3; i++) begin
				if (v[i] < mn) mn = v[i];
				if (v[i] > mx) mx = v[i];
			end
			md = mx - mn;
			ms = mx + mn;
			h[1] = (ms + 1) >>> 1;
			if (md == 0) begin
				h[0] = 0;
				h[2] = 0;
			end else begin
				h[2] = (ms < ONE) ? rounded_ratio(md, ms) : rounded_ratio(md, 2 * ONE - ms);
				if (v[0] == mx)
					num = 6 * md + v[1] - v[2];
				else if (v[1] == mx)
					num = 2 * md + v[2] - v[0];
				else
					num = 4 * md + v[0] - v[1];
				h[0] = rounded_ratio(num, 6 * md);
				if (h[0] > ONE)
					h[0] = h[0] - ONE;
			end
			for (int k = 0; k < 3; k++)
				m[k] = matrix_col(coef[k], h[0], h[1], h[2]);
			// Back to RGB.
			l = unit_clamp(m[1]);
			s = unit_clamp(m[2]);
			ls = (l * s + 32768) >>> 16;
			m2 = (l <= ONE / 2) ? l + ls : l + s - ls;
			m1 = 2 * l - m2;
			t = hue_wrap((m[0] % TURN) * 6);
			r[0] = channel_level(m1, m2, hue_wrap(t + 2 * ONE));
			r[1] = channel_level(m1, m2, t);
			r[2] = channel_level(m1, m2, hue_wrap(t - 2 * ONE));
		end else begin
			for (int k = 0; k < 3; k++)
				r[k] = matrix_col(coef[k], v[0], v[1], v[2]);
		end
		o.red_out   = q16_to_pix(r[0]);
		o.green_out = q16_to_pix(r[1]);
		o.blue_out  = q16_to_pix(r[2]);
		o.alpha_out = p.alpha;
		return o;
	endfunction

	assign pending = expected_pixels.size();

	// Track register writes, predict on input transfers, compare on output transfers.
	always @(posedge clk or negedge arst_n) begin
		pcm_out_t want;
		if (!arst_n) begin
			hls_on  = 1'b0;
			coef[0] = COEF_FIRST_RST;
			coef[1] = COEF_SECOND_RST;
			coef[2] = COEF_THIRD_RST;
			errors  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HLS_MODE:    hls_on  = cfg_wdata[0];
					REG_COEF_FIRST:  coef[0] = cfg_wdata;
					REG_COEF_SECOND: coef[1] = cfg_wdata;
					REG_COEF_THIRD:  coef[2] = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_pixels = {expected_pixels, predict_pixel(in_pix)};
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected output pixel %h", out_pix);
				end else begin
					want = expected_pixels.pop_front();
					if (out_pix.red_out !== want.red_out || out_pix.green_out !== want.green_out
						|| out_pix.blue_out !== want.blue_out
						|| out_pix.alpha_out !== want.alpha_out) begin
						errors++;
						if (errors <= 10)
							$display("pixel mismatch: expected %h, got %h", want, out_pix);
					end
				end
			end
		end
	end

endmodule

/* dv/pixel_color_matrix_hls_test.sv */
`timescale 1ns / 1ps

module pixel_color_matrix_hls_test;
	import pcm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 2 * DIV_LAT + 11 + 20;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	pcm_in_t              in_pix = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	pcm_out_t             out_pix;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HLS_MODE;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	int                   errors;
	int                   pending;
	int                   cycles = 0;
	bit                   no_gaps = 1'b0;
	bit                   hold_go = 1'b0;
	int                   pixels_sent = 0;

	pixel_color_matrix_hls dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_pix(in_pix),
		.out_valid(out_valid), .out_ready(out_ready), .out_pix(out_pix),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	pcm_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_pix(in_pix),
		.out_valid(out_valid), .out_ready(out_ready), .out_pix(out_pix),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pixel_color_matrix_hls_test: done, errors");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off while the sender keeps going.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(99) >= 27);
			end
		end
	end

	// Offer one pixel, with random idle cycles first, and hold it until the transfer.
	task automatic send_pixel(pcm_in_t p);
		while (!no_gaps && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_pix   <= p;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		pixels_sent++;
	endtask

	task automatic write_setting(logic mode, logic [CFG_W-1:0] c0, logic [CFG_W-1:0] c1,
		logic [CFG_W-1:0] c2);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_HLS_MODE;
		cfg_wdata <= {63'(0), mode};
		@(posedge clk);
		cfg_index <= REG_COEF_FIRST;
		cfg_wdata <= c0;
		@(posedge clk);
		cfg_index <= REG_COEF_SECOND;
		cfg_wdata <= c1;
		@(posedge clk);
		cfg_index <= REG_COEF_THIRD;
		cfg_wdata <= c2;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Four Q4.12 values: weights within +-2.0, offset within +-1.0.
	function automatic logic [CFG_W-1:0] mild_coefs();
		logic [15:0] w [4];
		for (int i = 0; i < 3; i++)
			w[i] = 16'($signed($urandom_range(16384)) - 8192);
		w[3] = 16'($signed($urandom_range(8192)) - 4096);
		return {w[3], w[2], w[1], w[0]};
	endfunction

	function automatic logic [CFG_W-1:0] wild_coefs();
		return {$urandom, $urandom};
	endfunction

	function automatic pcm_in_t random_pixel();
		pcm_in_t p;
		logic [7:0] g;
		p = $urandom;
		if ($urandom_range(9) == 0) begin
			g = 8'($urandom);
			p.red = g;
			p.green = g;
			p.blue = g;
		end
		return p;
	endfunction

	task automatic send_directed();
		pcm_in_t list [20];
		list[0]  = {8'h00, 8'h00, 8'h00, 8'h00};
		list[1]  = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
		list[2]  = {8'h80, 8'h80, 8'h80, 8'h7F};
		list[3]  = {8'hFF, 8'h00, 8'h00, 8'h01};
		list[4]  = {8'h00, 8'hFF, 8'h00, 8'h80};
		list[5]  = {8'h00, 8'h00, 8'hFF, 8'hFE};
		list[6]  = {8'hFF, 8'hFF, 8'h00, 8'h55};
		list[7]  = {8'h00, 8'hFF, 8'hFF, 8'hAA};
		list[8]  = {8'hFF, 8'h00, 8'hFF, 8'h33};
		// Red largest with blue slightly above green: hue lies just below a full turn.
		list[9]  = {8'hFF, 8'h00, 8'h01, 8'h10};
		list[10] = {8'hFE, 8'hFE, 8'hFF, 8'h20};
		list[11] = {8'h01, 8'h00, 8'h00, 8'h40};
		list[12] = {8'h7F, 8'h80, 8'h7F, 8'hC0};
		list[13] = {8'h40, 8'h80, 8'hC0, 8'hE0};
		list[14] = {8'hC0, 8'h80, 8'h40, 8'h0F};
		list[15] = {8'h7F, 8'h7F, 8'h80, 8'hF0};
		list[16] = {8'h80, 8'h7F, 8'h7F, 8'h3C};
		list[17] = {8'hAA, 8'h55, 8'hAA, 8'h5A};
		list[18] = {8'h55, 8'hAA, 8'h55, 8'hA5};
		list[19] = {8'h01, 8'h01, 8'h01, 8'h00};
		foreach (list[i])
			send_pixel(list[i]);
	endtask

	task automatic send_random(int count);
		repeat (count) begin
			if (pixels_sent > 600)
				hold_go = 1'b1;
			no_gaps = (pixels_sent >= 1000 && pixels_sent < 1250);
			send_pixel(random_pixel());
		end
	endtask

	// Reset, then a series of settings; the first phase runs on the reset values.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		send_random(190);

		write_setting(1'b1, COEF_FIRST_RST, COEF_SECOND_RST, COEF_THIRD_RST);
		send_directed();
		send_random(190);

		// Hue turned by a third and lightness raised.
		write_setting(1'b1, {16'h0555, 48'h0000_0000_1000}, {16'h0400, 48'h0000_1000_0000},
			{16'h0000, 48'h1000_0000_0000});
		send_random(200);

		write_setting(1'b0, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
		send_random(100);

		write_setting(1'b1, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
		send_random(100);

		write_setting(1'b1, mild_coefs(), mild_coefs(), mild_coefs());
		send_random(250);

		write_setting(1'b0, mild_coefs(), mild_coefs(), mild_coefs());
		send_random(250);

		write_setting(1'b1, wild_coefs(), wild_coefs(), wild_coefs());
		send_random(200);

		write_setting(1'b0, wild_coefs(), wild_coefs(), wild_coefs());
		send_random(200);

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("pixel_color_matrix_hls_test: done, clean");
		else
			$display("pixel_color_matrix_hls_test: done, errors");
		$finish;
	end

endmodule

/* pixel_color_matrix_hls.f */
+incdir+design
design/pcm_pkg.sv
design/pcm_delay.sv
design/pcm_div.sv
design/pixel_color_matrix_hls.sv
dv/pcm_checker.sv
dv/pixel_color_matrix_hls_test.sv
